FILE: hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps
package spq_pkg;

    localparam int DATA_W   = 32;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_FETCH  = 1'b1
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    // Broadcast control from the queue control to every cell.
    typedef struct packed {
        logic do_insert;
        logic do_fetch;
    } t_cell_ctrl;

endpackage

FILE: hdl/spq_ifs.sv
// Valid/ready channel interfaces for command and result transactions.
// Depends on spq_pkg for payload widths.
`timescale 1ns / 1ps
interface spq_in_if;
    import spq_pkg::*;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic signed [DATA_W-1:0] data_in;
    logic [PRIO_W-1:0] priority_in;

    modport source (output valid, output cmd, output data_in, output priority_in,
                    input ready);
    modport sink   (input valid, input cmd, input data_in, input priority_in,
                    output ready);
endinterface

interface spq_out_if;
    import spq_pkg::*;
    logic                valid;
    logic                ready;
    logic signed [DATA_W-1:0] data_out;
    logic [PRIO_W-1:0]   priority_out;
    logic [STATUS_W-1:0] status;
    logic [FILL_W-1:0]   fill_count;
    logic                now_empty;

    modport source (output valid, output data_out, output priority_out, output status,
                    output fill_count, output now_empty, input ready);
    modport sink   (input valid, input data_out, input priority_out, input status,
                    input fill_count, input now_empty, output ready);
endinterface

FILE: hdl/spq_cell.sv
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
// Depends on spq_pkg for the control struct.
`timescale 1ns / 1ps
module spq_cell #(
    parameter int PW = 8
) (
    input  logic                      i_clk,
    input  spq_pkg::t_cell_ctrl       i_ctrl,
    input  logic                      i_occupied,
    input  logic [spq_pkg::DATA_W-1:0] i_new_data,
    input  logic [PW-1:0]             i_new_prio,
    input  logic                      i_prev_keep,
    input  logic [spq_pkg::DATA_W-1:0] i_prev_data,
    input  logic [PW-1:0]             i_prev_prio,
    input  logic [spq_pkg::DATA_W-1:0] i_next_data,
    input  logic [PW-1:0]             i_next_prio,
    output logic                      o_keep,
    output logic [spq_pkg::DATA_W-1:0] o_data,
    output logic [PW-1:0]             o_prio
);
    import spq_pkg::*;

    logic [DATA_W-1:0] r_data, n_data;
    logic [PW-1:0]     r_prio, n_prio;

    // Stay put when holding an entry that ranks at or above the newcomer.
    assign o_keep = i_occupied && (r_prio >= i_new_prio);

    always_comb begin
        n_data = r_data;
        n_prio = r_prio;
        if (i_ctrl.do_insert && !o_keep) begin
            if (i_prev_keep) begin
                n_data = i_new_data;
                n_prio = i_new_prio;
            end else begin
                n_data = i_prev_data;
                n_prio = i_prev_prio;
            end
        end else if (i_ctrl.do_fetch) begin
            n_data = i_next_data;
            n_prio = i_next_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_prio <= n_prio;
    end

    assign o_data = r_data;
    assign o_prio = r_prio;
endmodule

FILE: hdl/sorted_priority_queue_unit.sv
// Sorted priority queue: a chain of DEPTH cells kept in descending priority order.
// The result of each accepted command is registered in the output register.
// Throughput: one command per cycle while the result consumer is ready; each cell compares and shifts in parallel.
// Reset: i_rst_n (synchronous) clears the occupancy count and the result valid flag;
// cell contents stay undefined until written. Depends on spq_pkg, spq_ifs, spq_cell.
`timescale 1ns / 1ps
module sorted_priority_queue_unit #(
    parameter int DEPTH          = 16,
    parameter int PRIORITY_WIDTH = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);
    import spq_pkg::*;

    localparam int OCC_W = $clog2(DEPTH + 1);

    // Occupancy counter and result register.
    logic [OCC_W-1:0]    r_occ, n_occ;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_data_out, n_data_out;
    logic [PRIO_W-1:0]   r_prio_out, n_prio_out;
    t_status             r_status, n_status;
    logic [FILL_W-1:0]   r_fill;
    logic                r_empty;

    logic                accept;
    logic                full, empty;
    t_cell_ctrl          ctrl;
    logic [PRIORITY_WIDTH-1:0] new_prio;
    logic [31:0]         prio_in_ext;
    logic [31:0]         prio_front_ext;
    logic [31:0]         occ_ext;

    // Cell chain taps.
    logic                    w_keep [DEPTH];
    logic [DATA_W-1:0]       w_data [DEPTH];
    logic [PRIORITY_WIDTH-1:0] w_prio [DEPTH];

    // Take a new command whenever the result register is free or being drained.
    assign accept      = i_in.valid && i_in.ready;
    assign i_in.ready  = !r_out_valid || o_out.ready;

    assign full  = (r_occ == OCC_W'(DEPTH));
    assign empty = (r_occ == '0);

    // Keep only the low PRIORITY_WIDTH bits of the incoming priority.
    assign prio_in_ext = 32'(i_in.priority_in);
    assign new_prio    = prio_in_ext[PRIORITY_WIDTH-1:0];

    always_comb begin
        ctrl.do_insert = accept && (t_cmd'(i_in.cmd) == CMD_INSERT) && !full;
        ctrl.do_fetch  = accept && (t_cmd'(i_in.cmd) == CMD_FETCH) && !empty;
    end

    // Build the chain: cell i looks back at cell i-1 and ahead at cell i+1.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                      prev_keep;
            logic [DATA_W-1:0]         prev_data, next_data;
            logic [PRIORITY_WIDTH-1:0] prev_prio, next_prio;
            logic                      occupied;

            assign occupied = (OCC_W'(gi) < r_occ);

            if (gi == 0) begin : g_head
                assign prev_keep = 1'b1;
                assign prev_data = w_data[gi];
                assign prev_prio = w_prio[gi];
            end else begin : g_body
                assign prev_keep = w_keep[gi-1];
                assign prev_data = w_data[gi-1];
                assign prev_prio = w_prio[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign next_data = w_data[gi];
                assign next_prio = w_prio[gi];
            end else begin : g_mid
                assign next_data = w_data[gi+1];
                assign next_prio = w_prio[gi+1];
            end

            spq_cell #(
                .PW (PRIORITY_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (ctrl),
                .i_occupied  (occupied),
                .i_new_data  (i_in.data_in),
                .i_new_prio  (new_prio),
                .i_prev_keep (prev_keep),
                .i_prev_data (prev_data),
                .i_prev_prio (prev_prio),
                .i_next_data (next_data),
                .i_next_prio (next_prio),
                .o_keep      (w_keep[gi]),
                .o_data      (w_data[gi]),
                .o_prio      (w_prio[gi])
            );
        end
    endgenerate

    // Result fields and next occupancy.
    assign prio_front_ext = 32'(w_prio[0]);

    always_comb begin
        n_occ      = r_occ;
        n_data_out = '0;
        n_prio_out = '0;
        n_status   = STATUS_OK;
        if (t_cmd'(i_in.cmd) == CMD_INSERT) begin
            if (full) begin
                n_status = STATUS_FULL;
            end else begin
                n_occ = r_occ + OCC_W'(1);
            end
        end else begin
            if (empty) begin
                n_status = STATUS_EMPTY;
            end else begin
                n_occ      = r_occ - OCC_W'(1);
                n_data_out = w_data[0];
                n_prio_out = prio_front_ext[PRIO_W-1:0];
            end
        end
    end

    // Report the count in five bits; it wraps for deep configurations.
    assign occ_ext = 32'(n_occ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_occ       <= n_occ;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the result payload with each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data_out <= n_data_out;
            r_prio_out <= n_prio_out;
            r_status   <= n_status;
            r_fill     <= occ_ext[FILL_W-1:0];
            r_empty    <= (n_occ == '0);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.data_out     = r_data_out;
    assign o_out.priority_out = r_prio_out;
    assign o_out.status       = r_status;
    assign o_out.fill_count   = r_fill;
    assign o_out.now_empty    = r_empty;

    // The count never passes the chain length.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(DEPTH))
        else $error("occupancy exceeds depth");

    // A refused insert leaves the chain full.
    a_full_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && t_cmd'(i_in.cmd) == CMD_INSERT && full) |=>
        (r_status == STATUS_FULL && full))
        else $error("refused insert changed occupancy");

    // An empty fetch reports the empty flag.
    a_empty_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && t_cmd'(i_in.cmd) == CMD_FETCH && empty) |=>
        (r_status == STATUS_EMPTY && r_empty && empty))
        else $error("empty fetch reported wrongly");

    // The two front entries stay in descending order.
    a_front_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ >= OCC_W'(2)) |-> (w_prio[0] >= w_prio[1]))
        else $error("front entries out of order");
endmodule
